[sv/bpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, command/status bundles between controller and
// datapath, and the Q8.24 rounding multiply.
// ----------------------------------------------------------------------------
package bpd_pkg;

   localparam int MaxOrder = 6;
   localparam int NTerms   = (MaxOrder + 1) * (MaxOrder + 2) / 2;
   localparam int OrdW     = $clog2(MaxOrder + 1);
   localparam int IdxW     = $clog2(NTerms);

   localparam int CoordW   = 32;
   localparam int CoefW    = 48;
   localparam int FracQ    = 24;
   localparam int CoefFrac = 32;
   localparam int AccW     = 56;
   localparam int QProdW   = 2 * CoordW;
   localparam int QSatW    = QProdW - FracQ;

   localparam int OpW      = 2;
   localparam int OrderW   = 3;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 32;

   localparam logic [OpW-1:0] OpLoadX = 2'd0;
   localparam logic [OpW-1:0] OpLoadY = 2'd1;
   localparam logic [OpW-1:0] OpMap   = 2'd2;

   localparam logic [CsrAddrW-1:0] CsrAddrOrder = 2'd0;
   localparam logic [OrderW-1:0]   OrderReset   = 3'd1;

   localparam int TermX = 2;
   localparam int TermY = 1;

   localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
   localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
   localparam logic signed [CoordW-1:0] OneCoord = 32'sh0100_0000;
   localparam logic signed [CoefW-1:0]  OneCoef  = 48'sh0001_0000_0000;
   localparam logic signed [QProdW-1:0] QRound   = QProdW'(2 ** (FracQ - 1));

   typedef struct packed {
      logic            start;
      logic            load_x;
      logic            load_y;
      logic            pow_en;
      logic [OrdW-1:0] pow_k;
      logic            term_en;
      logic [OrdW-1:0] term_i;
      logic [OrdW-1:0] term_j;
      logic [IdxW-1:0] term_n;
      logic            commit;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_stall;
   } stat_type;

   // {saturated, round(a*b / 2^24) clamped to 32 bits}
   function automatic logic [CoordW:0] mul_q24(input logic signed [CoordW-1:0] a,
                                               input logic signed [CoordW-1:0] b);
      logic signed [QProdW-1:0] p;
      logic signed [QSatW-1:0]  s;
      logic [CoordW:0]          r;
      p = QProdW'(a) * QProdW'(b) + QRound;
      s = $signed(p[QProdW-1:FracQ]);
      if (s > QSatW'(CoordMax)) begin
         r = {1'b1, CoordMax};
      end else if (s < QSatW'(CoordMin)) begin
         r = {1'b1, CoordMin};
      end else begin
         r = {1'b0, s[CoordW-1:0]};
      end
      return r;
   endfunction

   // value of a coefficient entry that was never loaded (identity map)
   function automatic logic signed [CoefW-1:0] coef_reset(input logic is_y,
                                                         input logic [IdxW-1:0] n);
      logic signed [CoefW-1:0] r;
      r = '0;
      if (!is_y && n == IdxW'(TermX)) begin
         r = OneCoef;
      end
      if (is_y && n == IdxW'(TermY)) begin
         r = OneCoef;
      end
      return r;
   endfunction

endpackage

[sv/bivariate_poly_distortion.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bivariate_poly_distortion: fixed-point bivariate polynomial point mapper
// Maps (x,y) through two polynomials of the configured total degree.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: op selects a coefficient load (x or y table) or a point map.
//  A load beat gives no response; an index past the
//  table or an unknown op is dropped.
//  A map beat gives one rsp beat with mapped_x, mapped_y and saturated.
//  The term multiply-accumulate pipeline issues one term per cycle. One map
//  runs at a time and req_ready is low meanwhile, so a new map is accepted
//  only after the previous one has committed its result.
//  csr port: register 0 (address 0) is poly_order, 0 acts as 1 and values
//  above the maximum act as the maximum. Write it only while idle.
//  Reset: order 1, coefficient tables hold the identity map, no response
//  pending. A stalled rsp beat waits in the output register; a new beat is
//  still accepted and its result is held back until the register frees.
// ----------------------------------------------------------------------------
module bivariate_poly_distortion (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic [4:0]                          req_coef_index,
   input  logic signed [47:0]                  req_coef_value,
   input  logic signed [31:0]                  req_point_x,
   input  logic signed [31:0]                  req_point_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_mapped_x,
   output logic signed [31:0]                  rsp_mapped_y,
   output logic                                rsp_saturated,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpd_pkg::CsrAddrW-1:0]        csr_paddr,
   input  logic [bpd_pkg::CsrDataW-1:0]        csr_pwdata,
   output logic [bpd_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import bpd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bpd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .stat           (stat),
      .cmd            (cmd)
   );

   bpd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_mapped_x   (rsp_mapped_x),
      .rsp_mapped_y   (rsp_mapped_y),
      .rsp_saturated  (rsp_saturated)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && !rsp_ready))
      else $error("result committed over a pending beat");

   a_map_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OpMap) |=> !req_ready)
      else $error("map beat did not block the request channel");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pow_en && cmd.term_en) && !(cmd.commit && stat.pipe_busy))
      else $error("sequencer overlap");

endmodule

[sv/bpd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_ctrl: sequencer and configuration register
// Accepts beats, walks the power steps and the term sweep, waits for the
// datapath pipeline to drain and commits the result.
// ----------------------------------------------------------------------------
module bpd_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bpd_pkg::OpW-1:0]         req_op,
   input  logic [4:0]                      req_coef_index,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpd_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [bpd_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [bpd_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                            csr_pready,
   input  bpd_pkg::stat_type               stat,
   output bpd_pkg::cmd_type                cmd
);
   import bpd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_POWER  = 5'b00010,
      ST_TERM   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [OrdW-1:0]   k_ff, k_in;
   logic [OrdW-1:0]   d_ff, d_in;
   logic [OrdW-1:0]   i_ff, i_in;
   logic [IdxW-1:0]   n_ff, n_in;
   logic [OrderW-1:0] order_ff, order_in;
   logic [OrdW-1:0]   eff_order;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_prdata = CsrDataW'(order_ff);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CsrAddrOrder);
   assign order_in   = csr_wr ? csr_pwdata[OrderW-1:0] : order_ff;
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      if (order_ff == '0) begin
         eff_order = OrdW'(1);
      end else if (int'(order_ff) > MaxOrder) begin
         eff_order = OrdW'(MaxOrder);
      end else begin
         eff_order = OrdW'(order_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OpLoadX: cmd.load_x = (int'(req_coef_index) < NTerms);
                  OpLoadY: cmd.load_y = (int'(req_coef_index) < NTerms);
                  OpMap: begin
                     cmd.start = 1'b1;
                     k_in      = OrdW'(1);
                     state_in  = ST_POWER;
                  end
                  default: ;
               endcase
            end
         end
         ST_POWER: begin
            cmd.pow_en = 1'b1;
            cmd.pow_k  = k_ff;
            if (k_ff == eff_order) begin
               d_in     = '0;
               i_in     = '0;
               n_in     = '0;
               state_in = ST_TERM;
            end else begin
               k_in = k_ff + OrdW'(1);
            end
         end
         ST_TERM: begin
            cmd.term_en = 1'b1;
            cmd.term_i  = i_ff;
            cmd.term_j  = d_ff - i_ff;
            cmd.term_n  = n_ff;
            n_in        = n_ff + IdxW'(1);
            if (i_ff == d_ff) begin
               i_in = '0;
               if (d_ff == eff_order) begin
                  state_in = ST_DRAIN;
               end else begin
                  d_in = d_ff + OrdW'(1);
               end
            end else begin
               i_in = i_ff + OrdW'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.out_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         order_ff <= OrderReset;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      d_ff <= d_in;
      i_ff <= i_in;
      n_ff <= n_in;
   end

endmodule

[sv/bpd_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_dpath: coefficient stores, power registers and term MAC pipeline
// Stage 1 forms the term and reads both coefficients, stage 2 multiplies in
// two partial products, stage 3 rounds, stage 4 accumulates.
// ----------------------------------------------------------------------------
module bpd_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bpd_pkg::cmd_type                    cmd,
   output bpd_pkg::stat_type                   stat,
   input  logic [4:0]                          req_coef_index,
   input  logic signed [bpd_pkg::CoefW-1:0]    req_coef_value,
   input  logic signed [bpd_pkg::CoordW-1:0]   req_point_x,
   input  logic signed [bpd_pkg::CoordW-1:0]   req_point_y,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [bpd_pkg::CoordW-1:0]   rsp_mapped_x,
   output logic signed [bpd_pkg::CoordW-1:0]   rsp_mapped_y,
   output logic                                rsp_saturated
);
   import bpd_pkg::*;

   localparam int LoW   = CoefW - CoordW;
   localparam int AW    = 2 * CoordW;
   localparam int BW    = CoordW + LoW + 1;
   localparam int SumW  = AW + LoW + 1;
   localparam int ProdW = SumW - CoefFrac;
   localparam logic signed [SumW-1:0] ProdHalf = SumW'(1) << (CoefFrac - 1);

   logic signed [CoefW-1:0]  coef_x_mem [NTerms];
   logic signed [CoefW-1:0]  coef_y_mem [NTerms];
   logic [NTerms-1:0]        vld_x_ff, vld_x_in;
   logic [NTerms-1:0]        vld_y_ff, vld_y_in;

   logic signed [CoordW-1:0] x_ff, y_ff;
   logic signed [CoordW-1:0] pwx_ff, pwx_in, pwy_ff, pwy_in;
   logic signed [CoordW-1:0] px_ff [MaxOrder+1];
   logic signed [CoordW-1:0] py_ff [MaxOrder+1];
   logic                     flag_ff, flag_in;

   logic [CoordW:0]          powx_r, powy_r, term_r;

   logic signed [CoordW-1:0] t_ff;
   logic signed [CoefW-1:0]  rdx_ff, rdy_ff;
   logic                     rdvx_ff, rdvy_ff;
   logic [IdxW-1:0]          rdn_ff;
   logic                     s1_ff, s2_ff, s3_ff;

   logic signed [CoefW-1:0]  cx, cy;
   logic signed [CoordW-1:0] hi_x, hi_y;
   logic signed [LoW:0]      lo_x, lo_y;
   logic signed [AW-1:0]     ax_ff, ax_in, ay_ff, ay_in;
   logic signed [BW-1:0]     bx_ff, bx_in, by_ff, by_in;
   logic signed [SumW-1:0]   sum_x, sum_y;
   logic signed [ProdW-1:0]  prx_ff, prx_in, pry_ff, pry_in;
   logic signed [AccW-1:0]   accx_ff, accx_in, accy_ff, accy_in;

   logic signed [CoordW-1:0] satx, saty;
   logic                     satfx, satfy;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CoordW-1:0] mx_ff, my_ff;
   logic                     ms_ff;

   // coefficient stores: valid bits stand in for the identity reset
   always_comb begin
      vld_x_in = vld_x_ff;
      vld_y_in = vld_y_ff;
      if (cmd.load_x) begin
         vld_x_in[req_coef_index[IdxW-1:0]] = 1'b1;
      end
      if (cmd.load_y) begin
         vld_y_in[req_coef_index[IdxW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         coef_x_mem[req_coef_index[IdxW-1:0]] <= req_coef_value;
      end
      if (cmd.load_y) begin
         coef_y_mem[req_coef_index[IdxW-1:0]] <= req_coef_value;
      end
      rdx_ff  <= coef_x_mem[cmd.term_n];
      rdy_ff  <= coef_y_mem[cmd.term_n];
      rdvx_ff <= vld_x_ff[cmd.term_n];
      rdvy_ff <= vld_y_ff[cmd.term_n];
      rdn_ff  <= cmd.term_n;
   end

   // powers and term
   always_comb begin
      powx_r  = mul_q24(pwx_ff, x_ff);
      powy_r  = mul_q24(pwy_ff, y_ff);
      term_r  = mul_q24(px_ff[cmd.term_i], py_ff[cmd.term_j]);
      pwx_in  = pwx_ff;
      pwy_in  = pwy_ff;
      flag_in = flag_ff;
      if (cmd.start) begin
         pwx_in  = OneCoord;
         pwy_in  = OneCoord;
         flag_in = 1'b0;
      end else if (cmd.pow_en) begin
         pwx_in  = powx_r[CoordW-1:0];
         pwy_in  = powy_r[CoordW-1:0];
         flag_in = flag_ff | powx_r[CoordW] | powy_r[CoordW];
      end else if (cmd.term_en) begin
         flag_in = flag_ff | term_r[CoordW];
      end
   end

   always_ff @(posedge clock) begin
      pwx_ff  <= pwx_in;
      pwy_ff  <= pwy_in;
      flag_ff <= flag_in;
      t_ff    <= term_r[CoordW-1:0];
      if (cmd.start) begin
         x_ff     <= req_point_x;
         y_ff     <= req_point_y;
         px_ff[0] <= OneCoord;
         py_ff[0] <= OneCoord;
      end
      if (cmd.pow_en) begin
         px_ff[cmd.pow_k] <= powx_r[CoordW-1:0];
         py_ff[cmd.pow_k] <= powy_r[CoordW-1:0];
      end
   end

   // coefficient times term, split into high signed and low unsigned halves
   always_comb begin
      cx    = rdvx_ff ? rdx_ff : coef_reset(1'b0, rdn_ff);
      cy    = rdvy_ff ? rdy_ff : coef_reset(1'b1, rdn_ff);
      hi_x  = $signed(cx[CoefW-1:LoW]);
      hi_y  = $signed(cy[CoefW-1:LoW]);
      lo_x  = $signed({1'b0, cx[LoW-1:0]});
      lo_y  = $signed({1'b0, cy[LoW-1:0]});
      ax_in = AW'(hi_x) * AW'(t_ff);
      ay_in = AW'(hi_y) * AW'(t_ff);
      bx_in = BW'(lo_x) * BW'(t_ff);
      by_in = BW'(lo_y) * BW'(t_ff);
      sum_x = (SumW'(ax_ff) <<< LoW) + SumW'(bx_ff) + ProdHalf;
      sum_y = (SumW'(ay_ff) <<< LoW) + SumW'(by_ff) + ProdHalf;
      prx_in = $signed(sum_x[SumW-1:CoefFrac]);
      pry_in = $signed(sum_y[SumW-1:CoefFrac]);
      if (cmd.start) begin
         accx_in = '0;
         accy_in = '0;
      end else if (s3_ff) begin
         accx_in = accx_ff + AccW'(prx_ff);
         accy_in = accy_ff + AccW'(pry_ff);
      end else begin
         accx_in = accx_ff;
         accy_in = accy_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      prx_ff  <= prx_in;
      pry_ff  <= pry_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
   end

   // final clamp and output register
   always_comb begin
      satfx = 1'b1;
      satfy = 1'b1;
      if (accx_ff > AccW'(CoordMax)) begin
         satx = CoordMax;
      end else if (accx_ff < AccW'(CoordMin)) begin
         satx = CoordMin;
      end else begin
         satx  = accx_ff[CoordW-1:0];
         satfx = 1'b0;
      end
      if (accy_ff > AccW'(CoordMax)) begin
         saty = CoordMax;
      end else if (accy_ff < AccW'(CoordMin)) begin
         saty = CoordMin;
      end else begin
         saty  = accy_ff[CoordW-1:0];
         satfy = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         mx_ff <= satx;
         my_ff <= saty;
         ms_ff <= flag_ff | satfx | satfy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_x_ff     <= '0;
         vld_y_ff     <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         s3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_x_ff     <= vld_x_in;
         vld_y_ff     <= vld_y_in;
         s1_ff        <= cmd.term_en;
         s2_ff        <= s1_ff;
         s3_ff        <= s2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.pipe_busy = s1_ff | s2_ff | s3_ff;
   assign stat.out_stall = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mapped_x   = mx_ff;
   assign rsp_mapped_y   = my_ff;
   assign rsp_saturated  = ms_ff;

endmodule
